### src/frame_fragment_sequence_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of the fragment tracker.
// ----------------------------------------------------------------------------
`ifndef FRAME_FRAGMENT_SEQUENCE_TRACKER_DEFINES_SVH
`define FRAME_FRAGMENT_SEQUENCE_TRACKER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FFST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define FFST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ffst_pkg.sv
// ----------------------------------------------------------------------------
// ffst_pkg
// Types and constants shared by the frame fragment sequence tracker.
// ----------------------------------------------------------------------------
package ffst_pkg;

    // Largest fragment count a frame may announce.
    localparam logic [15:0] MAX_FRAME_FRAGMENTS = 16'd65535;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OLD_FRAME = 3'd0,
        ST_OLD_FRAG  = 3'd1,
        ST_ACCEPTED  = 3'd2,
        ST_COMPLETE  = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    // Reassembly state of the back end.
    typedef enum logic {
        TRK_IDLE,
        TRK_IN_FRAME
    } trk_state_t;

    // One received fragment header.
    typedef struct packed {
        logic [30:0] frame_number;
        logic [30:0] sequence_number;
        logic [15:0] fragments_in_frame;
        logic [30:0] frame_timestamp;
        logic [15:0] payload_bytes;
    } frag_t;

    // One result beat.
    typedef struct packed {
        status_t     status;
        logic [30:0] result_frame;
        logic [31:0] frame_bytes;
        logic [30:0] result_timestamp;
    } result_t;

endpackage

### src/ffst_front.sv
// ----------------------------------------------------------------------------
// ffst_front
// Input stage: takes fragment beats, clamps the fragment count and holds the
// beat until the queue takes it.
// ----------------------------------------------------------------------------
module ffst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  ffst_pkg::frag_t frag,
    input  logic           frag_valid,
    output logic           frag_ready,
    output ffst_pkg::frag_t front_item,
    output logic           front_valid,
    input  logic           front_ready
);
    import ffst_pkg::*;

    frag_t front_item_reg;
    frag_t front_item_next;
    logic  front_valid_reg;
    logic  front_valid_next;

    // The stage refills whenever it is empty or its beat leaves this cycle.
    assign frag_ready = !front_valid_reg || front_ready;

    // Clamp the announced fragment count into its legal range.
    always_comb
    begin
        front_item_next = front_item_reg;
        front_valid_next = front_valid_reg && !front_ready;
        if (frag_valid && frag_ready)
        begin
            front_item_next = frag;
            if (frag.fragments_in_frame == 16'd0)
            begin
                front_item_next.fragments_in_frame = 16'd1;
            end
            else if (frag.fragments_in_frame > MAX_FRAME_FRAGMENTS)
            begin
                front_item_next.fragments_in_frame = MAX_FRAME_FRAGMENTS;
            end
            front_valid_next = 1'b1;
        end
    end

    // Valid flag is control state and resets; the payload does not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

    assign front_item = front_item_reg;
    assign front_valid = front_valid_reg;

endmodule

### src/ffst_queue.sv
// ----------------------------------------------------------------------------
// ffst_queue
// Two-entry queue between the front and back ends so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module ffst_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  ffst_pkg::frag_t push_item,
    input  logic            push_valid,
    output logic            push_ready,
    output ffst_pkg::frag_t pop_item,
    output logic            pop_valid,
    input  logic            pop_ready
);
    import ffst_pkg::*;

    frag_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/ffst_back.sv
// ----------------------------------------------------------------------------
// ffst_back
// Reassembly engine: applies each fragment to the frame state and registers
// one result beat per fragment.
// ----------------------------------------------------------------------------
module ffst_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ffst_pkg::frag_t   head,
    input  logic              head_valid,
    output logic              head_ready,
    output ffst_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);
    import ffst_pkg::*;

    trk_state_t  state_reg;
    trk_state_t  state_next;
    logic [30:0] exp_seq_reg;
    logic [30:0] exp_seq_next;
    logic [30:0] latest_reg;
    logic [30:0] latest_next;
    logic [15:0] frag_exp_reg;
    logic [15:0] frag_exp_next;
    logic [15:0] frag_rcv_reg;
    logic [15:0] frag_rcv_next;
    logic [31:0] bytes_reg;
    logic [31:0] bytes_next;
    logic [30:0] ts_reg;
    logic [30:0] ts_next;
    result_t     result_reg;
    result_t     result_next;
    logic        result_valid_reg;
    logic        result_valid_next;

    logic        pop;
    logic        is_newer;
    logic        seq_old;
    logic        seq_ahead;
    logic        opens_single;
    logic [32:0] bytes_sum;
    logic [31:0] bytes_sat;
    logic [15:0] rcv_inc;
    logic        last_frag;

    // A fragment is taken when the result register is free or draining.
    assign pop        = head_valid && (!result_valid_reg || result_ready);
    assign head_ready = !result_valid_reg || result_ready;

    // Shared compares and the saturating byte add.
    assign is_newer     = head.frame_number > latest_reg;
    assign seq_old      = head.sequence_number < exp_seq_reg;
    assign seq_ahead    = head.sequence_number > exp_seq_reg;
    assign opens_single = head.fragments_in_frame == 16'd1;
    assign bytes_sum    = {1'b0, bytes_reg} + {17'd0, head.payload_bytes};
    assign bytes_sat    = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];
    assign rcv_inc      = frag_rcv_reg + 16'd1;
    assign last_frag    = rcv_inc >= frag_exp_reg;

    // Next reassembly state.
    always_comb
    begin
        state_next = state_reg;
        if (pop)
        begin
            case (state_reg)
                TRK_IDLE:
                begin
                    if (is_newer && !opens_single)
                    begin
                        state_next = TRK_IN_FRAME;
                    end
                end
                TRK_IN_FRAME:
                begin
                    if (seq_ahead || (!seq_old && last_frag))
                    begin
                        state_next = TRK_IDLE;
                    end
                end
                default:
                begin
                    state_next = TRK_IDLE;
                end
            endcase
        end
    end

    // Frame bookkeeping and the result beat.
    always_comb
    begin
        exp_seq_next      = exp_seq_reg;
        latest_next       = latest_reg;
        frag_exp_next     = frag_exp_reg;
        frag_rcv_next     = frag_rcv_reg;
        bytes_next        = bytes_reg;
        ts_next           = ts_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (pop)
        begin
            result_valid_next = 1'b1;
            case (state_reg)
                TRK_IDLE:
                begin
                    if (!is_newer)
                    begin
                        result_next.status           = ST_OLD_FRAME;
                        result_next.result_frame     = latest_reg;
                        result_next.frame_bytes      = 32'd0;
                        result_next.result_timestamp = 31'd0;
                    end
                    else
                    begin
                        // Opening fragment counts as the first one received.
                        frag_exp_next = head.fragments_in_frame;
                        frag_rcv_next = 16'd1;
                        ts_next       = head.frame_timestamp;
                        latest_next   = head.frame_number;
                        exp_seq_next  = head.sequence_number + 31'd1;
                        bytes_next    = {16'd0, head.payload_bytes};
                        result_next.status           = opens_single ? ST_COMPLETE
                                                                    : ST_ACCEPTED;
                        result_next.result_frame     = head.frame_number;
                        result_next.frame_bytes      = {16'd0, head.payload_bytes};
                        result_next.result_timestamp = head.frame_timestamp;
                    end
                end
                TRK_IN_FRAME:
                begin
                    if (seq_old)
                    begin
                        result_next.status           = ST_OLD_FRAG;
                        result_next.result_frame     = latest_reg;
                        result_next.frame_bytes      = bytes_reg;
                        result_next.result_timestamp = ts_reg;
                    end
                    else if (seq_ahead)
                    begin
                        // The skipping sender's frame number becomes the latest frame.
                        latest_next = head.frame_number;
                        result_next.status           = ST_REJECTED;
                        result_next.result_frame     = latest_reg;
                        result_next.frame_bytes      = bytes_reg;
                        result_next.result_timestamp = ts_reg;
                    end
                    else
                    begin
                        bytes_next    = bytes_sat;
                        frag_rcv_next = rcv_inc;
                        exp_seq_next  = exp_seq_reg + 31'd1;
                        result_next.status           = last_frag ? ST_COMPLETE
                                                                 : ST_ACCEPTED;
                        result_next.result_frame     = latest_reg;
                        result_next.frame_bytes      = bytes_sat;
                        result_next.result_timestamp = ts_reg;
                    end
                end
                default:
                begin
                    result_next = result_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= TRK_IDLE;
            exp_seq_reg      <= 31'd0;
            latest_reg       <= 31'd0;
            frag_exp_reg     <= 16'd0;
            frag_rcv_reg     <= 16'd0;
            bytes_reg        <= 32'd0;
            ts_reg           <= 31'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            exp_seq_reg      <= exp_seq_next;
            latest_reg       <= latest_next;
            frag_exp_reg     <= frag_exp_next;
            frag_rcv_reg     <= frag_rcv_next;
            bytes_reg        <= bytes_next;
            ts_reg           <= ts_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

### src/frame_fragment_sequence_tracker.sv
// ----------------------------------------------------------------------------
// frame_fragment_sequence_tracker
// Tracks reassembly of multi-fragment frames from received fragment headers.
// ----------------------------------------------------------------------------
// Usage:
//   The frag channel takes one fragment header per beat (frag_valid and
//   frag_ready). The result channel returns exactly one status beat per
//   fragment, in order (result_valid and result_ready).
//   A fragment passes an input register, a two-entry queue and the
//   reassembly engine, whose result register holds its status beat.
//   Throughput is one fragment per cycle while result_ready is high; the engine
//   decides each fragment with a few compares and one 32-bit saturating add.
//   When result_ready is low, the result register holds its beat, the queue
//   fills, and frag_ready drops once the input register and the queue are
//   full; at most four fragments are in flight. Nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) empties all stages, drops any pending
//   results and returns the engine to idle with the latest frame at zero.
// ----------------------------------------------------------------------------
module frame_fragment_sequence_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  ffst_pkg::frag_t   frag,
    input  logic              frag_valid,
    output logic              frag_ready,
    output ffst_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);
    import ffst_pkg::*;

    frag_t front_item;
    logic  front_valid;
    logic  front_ready;
    frag_t head;
    logic  head_valid;
    logic  head_ready;

    // Input register and count clamp.
    ffst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frag        (frag),
        .frag_valid  (frag_valid),
        .frag_ready  (frag_ready),
        .front_item  (front_item),
        .front_valid (front_valid),
        .front_ready (front_ready)
    );

    // Decoupling queue.
    ffst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (head),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready)
    );

    // Reassembly engine and result register.
    ffst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .head_ready   (head_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

### src/ffst_checker.sv
// ----------------------------------------------------------------------------
// ffst_checker
// Port-level assertions for the frame fragment sequence tracker.
// ----------------------------------------------------------------------------
`include "frame_fragment_sequence_tracker_defines.svh"

module ffst_checker (
    input logic              clk,
    input logic              rst_n,
    input ffst_pkg::frag_t   frag,
    input logic              frag_valid,
    input logic              frag_ready,
    input ffst_pkg::result_t result,
    input logic              result_valid,
    input logic              result_ready
);
    import ffst_pkg::*;

    logic res_stall;
    logic frag_stall;
    logic old_frame_beat;
    logic old_frame_clear;

    // Handshake stall terms and the old frame result shape.
    assign res_stall       = result_valid && !result_ready;
    assign frag_stall      = frag_valid && !frag_ready;
    assign old_frame_beat  = result_valid && (result.status == ST_OLD_FRAME);
    assign old_frame_clear = (result.frame_bytes == 32'd0) && (result.result_timestamp == 31'd0);

    // A stalled result beat holds its value.
    `FFST_ASSERT(a_result_hold, res_stall |=> result_valid && $stable(result), "result beat moved")

    // A stalled fragment beat holds its value.
    `FFST_ASSERT(a_frag_hold, frag_stall |=> frag_valid && $stable(frag), "frag beat moved")

    // No result beat follows a cycle with reset held.
    `FFST_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !result_valid, "result valid during reset")

    // A skipped old frame reports no bytes and no timestamp.
    `FFST_ASSERT(a_old_frame_empty, old_frame_beat |-> old_frame_clear, "old frame beat has data")

    // No result is valid at the clock edge that first samples reset released.
    `FFST_ASSERT(a_no_early_result, $rose(rst_n) |-> !result_valid, "result right after reset")

endmodule

bind frame_fragment_sequence_tracker ffst_checker u_ffst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frag         (frag),
    .frag_valid   (frag_valid),
    .frag_ready   (frag_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
);
